// File: rtl/dtpg_pkg.sv
// Shared types, constants and helper functions of the display test pattern generator.
package dtpg_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int COORD_W    = 9;
    localparam int DIM_W      = 10;
    localparam int PAT_W      = 3;
    localparam int WORD_W     = 24;
    localparam int BCNT_W     = 2;
    localparam int LEVEL_W    = 8;
    localparam int QUO_W      = 8;
    localparam int NUM_W      = COORD_W + LEVEL_W;
    localparam int BAR_IDX_W  = 3;
    localparam int BAR_H_W    = DIM_W - 3;
    localparam int DIV_STAGES = QUO_W / 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd3;

    localparam logic [PAT_W-1:0] PAT_BARS  = 3'd0;
    localparam logic [PAT_W-1:0] PAT_RAMP  = 3'd1;
    localparam logic [PAT_W-1:0] PAT_RED   = 3'd2;
    localparam logic [PAT_W-1:0] PAT_GREEN = 3'd3;
    localparam logic [PAT_W-1:0] PAT_BLUE  = 3'd4;
    localparam logic [PAT_W-1:0] PAT_WHITE = 3'd5;
    localparam logic [PAT_W-1:0] PAT_BLACK = 3'd6;

    localparam logic [PAT_W-1:0] RST_PATTERN = PAT_BARS;
    localparam logic             RST_FORMAT  = 1'b0;
    localparam logic [DIM_W-1:0] RST_WIDTH   = 10'd240;
    localparam logic [DIM_W-1:0] RST_HEIGHT  = 10'd240;

    localparam logic [BCNT_W-1:0] BCNT_RGB565 = 2'd2;
    localparam logic [BCNT_W-1:0] BCNT_RGB888 = 2'd3;

    localparam logic [LEVEL_W-1:0] LVL_FULL = 8'hFF;
    localparam logic [LEVEL_W-1:0] LVL_GREY = 8'h77;

    localparam logic [15:0] BAR565_MASK = 16'hFFDF;

    localparam logic [WORD_W-1:0] BAR_COLORS [8] = '{
        24'hFFFFFF, 24'h777777, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00
    };

    localparam logic [WORD_W-1:0] SOLID_COLORS [5] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic [BCNT_W-1:0] byte_count;
        logic              covered;
    } t_pix_out;

    typedef struct packed {
        logic [PAT_W-1:0]     pattern;
        logic                 wide;
        logic                 in_frame;
        logic                 bar_ok;
        logic [BAR_IDX_W-1:0] bar_idx;
        logic [LEVEL_W-1:0]   level;
        logic [DIM_W-1:0]     width;
        logic [NUM_W-1:0]     rem_full;
        logic [NUM_W-1:0]     rem_grey;
        logic [QUO_W-1:0]     q_full;
        logic [QUO_W-1:0]     q_grey;
    } t_div_data;

    function automatic logic [WORD_W-1:0] pack_color(input logic [WORD_W-1:0] rgb,
                                                     input logic wide);
        logic [WORD_W-1:0] res;
        if (wide) begin
            res = rgb;
        end else begin
            res = {8'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
        end
        return res;
    endfunction

    // Pick the scaled level that matches the bar's base channel value
    function automatic logic [LEVEL_W-1:0] bar_chan(input logic [LEVEL_W-1:0] base,
                                                    input logic [QUO_W-1:0] q_full,
                                                    input logic [QUO_W-1:0] q_grey);
        logic [LEVEL_W-1:0] res;
        if (base == LVL_FULL) begin
            res = q_full;
        end else if (base == LVL_GREY) begin
            res = q_grey;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// File: rtl/display_test_pattern_generator.sv
// Throughput: one item per cycle while the output is not stalled; six
// register stages, four of them a divider that resolves two quotient bits
// of channel*x/width per stage.
// Each stage holds its item while the next one is full, so bubbles fill up.
// Reset clears all stage valid bits and loads the registers with pattern 0,
// RGB565, width 240 and height 240.
module display_test_pattern_generator #(
    parameter int MAX_WIDTH  = dtpg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dtpg_pkg::t_pix_in                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dtpg_pkg::t_pix_out               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dtpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dtpg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [dtpg_pkg::PAT_W-1:0] r_pattern;
    logic                       r_wide;
    logic [dtpg_pkg::DIM_W-1:0] r_width;
    logic [dtpg_pkg::DIM_W-1:0] r_height;

    logic                       front_ready;
    dtpg_pkg::t_div_data        div_data  [dtpg_pkg::DIV_STAGES+1];
    logic                       div_valid [dtpg_pkg::DIV_STAGES+1];
    logic                       div_ready [dtpg_pkg::DIV_STAGES+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= dtpg_pkg::RST_PATTERN;
            r_wide    <= dtpg_pkg::RST_FORMAT;
            r_width   <= dtpg_pkg::RST_WIDTH;
            r_height  <= dtpg_pkg::RST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dtpg_pkg::REG_PATTERN: r_pattern <= i_cfg_data[dtpg_pkg::PAT_W-1:0];
                dtpg_pkg::REG_FORMAT:  r_wide    <= i_cfg_data[0];
                dtpg_pkg::REG_WIDTH:   r_width   <= i_cfg_data[dtpg_pkg::DIM_W-1:0];
                dtpg_pkg::REG_HEIGHT:  r_height  <= i_cfg_data[dtpg_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = !front_ready;

    dtpg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_ready   (front_ready),
        .i_pattern (r_pattern),
        .i_wide    (r_wide),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_valid   (div_valid[0]),
        .o_data    (div_data[0]),
        .i_ready   (div_ready[0])
    );

    for (genvar s = 0; s < dtpg_pkg::DIV_STAGES; s++) begin : g_div
        dtpg_div_stage #(
            .STEP (s)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[s]),
            .i_data  (div_data[s]),
            .o_ready (div_ready[s]),
            .o_valid (div_valid[s+1]),
            .o_data  (div_data[s+1]),
            .i_ready (div_ready[s+1])
        );
    end

    dtpg_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid[dtpg_pkg::DIV_STAGES]),
        .i_data  (div_data[dtpg_pkg::DIV_STAGES]),
        .o_ready (div_ready[dtpg_pkg::DIV_STAGES]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (!i_out_stall)
    );

    // The input stalls only when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_uncovered_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.covered) |-> (o_out_data.pixel_word == '0))
        else $error("uncovered pixel carries a color");

    a_rgb565_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.byte_count == dtpg_pkg::BCNT_RGB565)
            |-> (o_out_data.pixel_word[23:16] == 8'd0))
        else $error("16-bit pixel has upper byte set");

endmodule

// File: rtl/dtpg_front.sv
// First stage: dimension clamp, frame and bar decode, gradient numerators.
module dtpg_front #(
    parameter int MAX_WIDTH  = dtpg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dtpg_pkg::t_pix_in             i_data,
    output logic                          o_ready,
    input  logic [dtpg_pkg::PAT_W-1:0]    i_pattern,
    input  logic                          i_wide,
    input  logic [dtpg_pkg::DIM_W-1:0]    i_width,
    input  logic [dtpg_pkg::DIM_W-1:0]    i_height,
    output logic                          o_valid,
    output dtpg_pkg::t_div_data           o_data,
    input  logic                          i_ready
);

    logic                                r_valid;
    dtpg_pkg::t_div_data                 r_data;
    dtpg_pkg::t_div_data                 n_data;
    logic [dtpg_pkg::DIM_W-1:0]          w;
    logic [dtpg_pkg::DIM_W-1:0]          h;
    logic [dtpg_pkg::BAR_H_W-1:0]        bar_h;
    logic [dtpg_pkg::DIM_W-1:0]          y_ext;
    logic [dtpg_pkg::DIM_W-1:0]          thr;
    logic [dtpg_pkg::BAR_IDX_W-1:0]      cnt;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_width == '0) begin
            w = dtpg_pkg::DIM_W'(1);
        end else if (32'(i_width) > MAX_WIDTH) begin
            w = dtpg_pkg::DIM_W'(MAX_WIDTH);
        end else begin
            w = i_width;
        end
        if (i_height == '0) begin
            h = dtpg_pkg::DIM_W'(1);
        end else if (32'(i_height) > MAX_HEIGHT) begin
            h = dtpg_pkg::DIM_W'(MAX_HEIGHT);
        end else begin
            h = i_height;
        end

        bar_h = h[dtpg_pkg::DIM_W-1:3];
        y_ext = dtpg_pkg::DIM_W'(i_data.pixel_y);

        // Bar index: count the bar boundaries at or below this row
        cnt = '0;
        for (int k = 1; k < 8; k++) begin
            thr = dtpg_pkg::DIM_W'(k) * dtpg_pkg::DIM_W'(bar_h);
            if (y_ext >= thr) begin
                cnt = cnt + dtpg_pkg::BAR_IDX_W'(1);
            end
        end

        n_data          = '0;
        n_data.pattern  = i_pattern;
        n_data.wide     = i_wide;
        n_data.in_frame = (dtpg_pkg::DIM_W'(i_data.pixel_x) < w) && (y_ext < h);
        n_data.bar_ok   = (bar_h != '0) && (y_ext < {bar_h, 3'b000});
        n_data.bar_idx  = cnt;
        n_data.level    = i_data.pixel_y[dtpg_pkg::LEVEL_W-1:0];
        n_data.width    = w;
        n_data.rem_full = dtpg_pkg::NUM_W'(i_data.pixel_x) * dtpg_pkg::NUM_W'(dtpg_pkg::LVL_FULL);
        n_data.rem_grey = dtpg_pkg::NUM_W'(i_data.pixel_x) * dtpg_pkg::NUM_W'(dtpg_pkg::LVL_GREY);
        n_data.q_full   = '0;
        n_data.q_grey   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/dtpg_div_stage.sv
// One divider stage: two restoring quotient bits for both gradient levels.
module dtpg_div_stage #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dtpg_pkg::t_div_data i_data,
    output logic                o_ready,
    output logic                o_valid,
    output dtpg_pkg::t_div_data o_data,
    input  logic                i_ready
);

    localparam int BIT_HI = dtpg_pkg::QUO_W - 1 - 2 * STEP;
    localparam int BIT_LO = BIT_HI - 1;

    logic                          r_valid;
    dtpg_pkg::t_div_data           r_data;
    dtpg_pkg::t_div_data           n_data;
    logic [dtpg_pkg::NUM_W-1:0]    d_hi;
    logic [dtpg_pkg::NUM_W-1:0]    d_lo;
    logic [dtpg_pkg::NUM_W-1:0]    rf;
    logic [dtpg_pkg::NUM_W-1:0]    rg;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data = i_data;
        d_hi   = dtpg_pkg::NUM_W'(i_data.width) << BIT_HI;
        d_lo   = dtpg_pkg::NUM_W'(i_data.width) << BIT_LO;
        rf     = i_data.rem_full;
        rg     = i_data.rem_grey;

        if (rf >= d_hi) begin
            rf = rf - d_hi;
            n_data.q_full[BIT_HI] = 1'b1;
        end
        if (rf >= d_lo) begin
            rf = rf - d_lo;
            n_data.q_full[BIT_LO] = 1'b1;
        end
        if (rg >= d_hi) begin
            rg = rg - d_hi;
            n_data.q_grey[BIT_HI] = 1'b1;
        end
        if (rg >= d_lo) begin
            rg = rg - d_lo;
            n_data.q_grey[BIT_LO] = 1'b1;
        end

        n_data.rem_full = rf;
        n_data.rem_grey = rg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/dtpg_pack.sv
// Last stage: pattern select, color packing and the output register.
module dtpg_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dtpg_pkg::t_div_data i_data,
    output logic                o_ready,
    output logic                o_valid,
    output dtpg_pkg::t_pix_out  o_data,
    input  logic                i_ready
);

    logic                           r_valid;
    dtpg_pkg::t_pix_out             r_data;
    dtpg_pkg::t_pix_out             n_data;
    logic [dtpg_pkg::WORD_W-1:0]    base;
    logic [dtpg_pkg::WORD_W-1:0]    rgb;
    logic [dtpg_pkg::WORD_W-1:0]    word;
    logic [2:0]                     solid_idx;
    logic                           cov;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        base      = dtpg_pkg::BAR_COLORS[i_data.bar_idx];
        solid_idx = 3'(i_data.pattern - dtpg_pkg::PAT_RED);
        rgb       = '0;
        word      = '0;
        cov       = 1'b0;

        case (i_data.pattern)
            dtpg_pkg::PAT_BARS: begin
                rgb = {dtpg_pkg::bar_chan(base[23:16], i_data.q_full, i_data.q_grey),
                       dtpg_pkg::bar_chan(base[15:8],  i_data.q_full, i_data.q_grey),
                       dtpg_pkg::bar_chan(base[7:0],   i_data.q_full, i_data.q_grey)};
                word = dtpg_pkg::pack_color(rgb, i_data.wide);
                // Bars in 16-bit mode drop the low green bit
                if (!i_data.wide) begin
                    word = word & {8'd0, dtpg_pkg::BAR565_MASK};
                end
                cov = i_data.bar_ok;
            end
            dtpg_pkg::PAT_RAMP: begin
                rgb  = {i_data.level, i_data.level, i_data.level};
                word = dtpg_pkg::pack_color(rgb, i_data.wide);
                cov  = 1'b1;
            end
            dtpg_pkg::PAT_RED, dtpg_pkg::PAT_GREEN, dtpg_pkg::PAT_BLUE,
            dtpg_pkg::PAT_WHITE, dtpg_pkg::PAT_BLACK: begin
                word = dtpg_pkg::pack_color(dtpg_pkg::SOLID_COLORS[solid_idx], i_data.wide);
                cov  = 1'b1;
            end
            default: begin
                cov = 1'b0;
            end
        endcase

        if (!i_data.in_frame) begin
            cov = 1'b0;
        end

        n_data.pixel_word = cov ? word : '0;
        n_data.byte_count = i_data.wide ? dtpg_pkg::BCNT_RGB888 : dtpg_pkg::BCNT_RGB565;
        n_data.covered    = cov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: tb/tb_top.sv
// Testbench for the display test pattern generator: directed table plus random phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtpg_pkg::*;

    localparam logic [PAT_W-1:0] PAT_UNUSED = 3'd7;

    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int PRESSURE_PHASE  = 3;
    localparam int QUIET_PHASE     = 5;
    localparam int LONG_HOLD       = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam int QUIET_LIMIT     = 2000;
    localparam int MAX_PRINTS      = 40;

    localparam logic [WORD_W-1:0] BAR_TONES [8] = '{
        24'hFFFFFF, 24'h777777, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00
    };
    localparam logic [WORD_W-1:0] SOLID_TONES [5] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic               wide;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               typed;
        logic [WORD_W-1:0]  word;
        logic               cov;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // reset configuration, no register write yet
        '{PAT_BARS,   1'b0, 10'd240,  10'd240,  9'd0,   9'd0,   1'b1, 24'h000000, 1'b1},
        '{PAT_BARS,   1'b0, 10'd240,  10'd240,  9'd239, 9'd0,   1'b0, 24'h0,      1'b0},
        '{PAT_BARS,   1'b0, 10'd240,  10'd240,  9'd239, 9'd239, 1'b0, 24'h0,      1'b0},
        '{PAT_BARS,   1'b0, 10'd240,  10'd240,  9'd240, 9'd0,   1'b1, 24'h000000, 1'b0},
        '{PAT_BARS,   1'b0, 10'd240,  10'd240,  9'd0,   9'd240, 1'b1, 24'h000000, 1'b0},
        '{PAT_BARS,   1'b1, 10'd512,  10'd512,  9'd511, 9'd0,   1'b0, 24'h0,      1'b0},
        '{PAT_BARS,   1'b1, 10'd512,  10'd512,  9'd511, 9'd511, 1'b0, 24'h0,      1'b0},
        '{PAT_BARS,   1'b1, 10'd512,  10'd512,  9'd256, 9'd130, 1'b0, 24'h0,      1'b0},
        '{PAT_BARS,   1'b0, 10'd512,  10'd512,  9'd300, 9'd70,  1'b0, 24'h0,      1'b0},
        // height under eight: no bars at all
        '{PAT_BARS,   1'b0, 10'd512,  10'd7,    9'd5,   9'd3,   1'b1, 24'h000000, 1'b0},
        // the row past the eighth bar and the last row inside it
        '{PAT_BARS,   1'b0, 10'd512,  10'd20,   9'd5,   9'd16,  1'b1, 24'h000000, 1'b0},
        '{PAT_BARS,   1'b0, 10'd512,  10'd20,   9'd5,   9'd15,  1'b0, 24'h0,      1'b0},
        '{PAT_RAMP,   1'b1, 10'd512,  10'd512,  9'd0,   9'd511, 1'b1, 24'hFFFFFF, 1'b1},
        '{PAT_RAMP,   1'b1, 10'd512,  10'd512,  9'd0,   9'd256, 1'b1, 24'h000000, 1'b1},
        '{PAT_RAMP,   1'b0, 10'd512,  10'd512,  9'd511, 9'd255, 1'b1, 24'h00FFFF, 1'b1},
        '{PAT_RED,    1'b0, 10'd512,  10'd512,  9'd1,   9'd1,   1'b1, 24'h00F800, 1'b1},
        '{PAT_GREEN,  1'b0, 10'd512,  10'd512,  9'd1,   9'd1,   1'b1, 24'h0007E0, 1'b1},
        '{PAT_BLUE,   1'b0, 10'd512,  10'd512,  9'd1,   9'd1,   1'b1, 24'h00001F, 1'b1},
        '{PAT_WHITE,  1'b1, 10'd512,  10'd512,  9'd1,   9'd1,   1'b1, 24'hFFFFFF, 1'b1},
        '{PAT_BLACK,  1'b1, 10'd512,  10'd512,  9'd1,   9'd1,   1'b1, 24'h000000, 1'b1},
        '{PAT_RED,    1'b1, 10'd512,  10'd512,  9'd511, 9'd511, 1'b1, 24'hFF0000, 1'b1},
        '{PAT_UNUSED, 1'b1, 10'd512,  10'd512,  9'd3,   9'd3,   1'b1, 24'h000000, 1'b0},
        // zero width acts as one, oversized height and width saturate
        '{PAT_WHITE,  1'b0, 10'd0,    10'd1023, 9'd0,   9'd511, 1'b1, 24'h00FFFF, 1'b1},
        '{PAT_WHITE,  1'b0, 10'd0,    10'd1023, 9'd1,   9'd0,   1'b1, 24'h000000, 1'b0},
        '{PAT_GREEN,  1'b1, 10'd1023, 10'd1,    9'd511, 9'd0,   1'b1, 24'h00FF00, 1'b1},
        '{PAT_GREEN,  1'b1, 10'd1023, 10'd1,    9'd0,   9'd1,   1'b1, 24'h000000, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_pix_in               i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_pix_out              o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register copy used for prediction
    logic [PAT_W-1:0] cfg_pattern = RST_PATTERN;
    logic             cfg_wide    = RST_FORMAT;
    logic [DIM_W-1:0] cfg_width   = RST_WIDTH;
    logic [DIM_W-1:0] cfg_height  = RST_HEIGHT;

    t_pix_out expected_pixels [$];
    int       mismatch_count = 0;
    int       pixels_seen = 0;
    int       quiet_cycles = 0;
    int       stall_left = 0;
    bit       idle_on = 1'b0;
    bit       hold_request = 1'b0;

    display_test_pattern_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
        int unsigned res;
        res = 32'(v);
        if (res == 0) begin
            res = 1;
        end else if (res > lim) begin
            res = lim;
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] to_pixel_word(input logic [WORD_W-1:0] rgb,
                                                        input logic wide);
        int unsigned r, g, b;
        r = 32'(rgb[23:16]);
        g = 32'(rgb[15:8]);
        b = 32'(rgb[7:0]);
        if (wide) begin
            return rgb;
        end
        return WORD_W'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hF8) >> 3));
    endfunction

    function automatic t_pix_out predict_pixel(input t_pix_in p);
        t_pix_out          res;
        int unsigned       w, h, bar_h, chan, x, y;
        logic [WORD_W-1:0] rgb;
        logic [7:0]        lvl;
        w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        x = 32'(p.pixel_x);
        y = 32'(p.pixel_y);
        res.pixel_word = '0;
        res.byte_count = cfg_wide ? BCNT_RGB888 : BCNT_RGB565;
        res.covered    = 1'b0;
        if (x < w && y < h) begin
            case (cfg_pattern)
                PAT_BARS: begin
                    bar_h = h / 8;
                    if (bar_h != 0 && y / bar_h < 8) begin
                        // scale each channel of the bar color by x/width
                        for (int c = 0; c < 3; c++) begin
                            chan = 32'(BAR_TONES[3'(y / bar_h)][8*c +: 8]);
                            rgb[8*c +: 8] = 8'((chan * x) / w);
                        end
                        res.pixel_word = to_pixel_word(rgb, cfg_wide);
                        if (!cfg_wide) begin
                            res.pixel_word[5] = 1'b0;
                        end
                        res.covered = 1'b1;
                    end
                end
                PAT_RAMP: begin
                    lvl = p.pixel_y[7:0];
                    res.pixel_word = to_pixel_word({lvl, lvl, lvl}, cfg_wide);
                    res.covered = 1'b1;
                end
                PAT_RED, PAT_GREEN, PAT_BLUE, PAT_WHITE, PAT_BLACK: begin
                    res.pixel_word = to_pixel_word(SOLID_TONES[cfg_pattern - PAT_RED], cfg_wide);
                    res.covered = 1'b1;
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] pixel %0d: %s got 0x%0h, want 0x%0h",
                     $realtime, pixels_seen, field, got, want);
        end
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [PAT_W-1:0] pat, input logic wide,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(REG_PATTERN, CFG_DATA_W'(pat));
        write_reg(REG_FORMAT, CFG_DATA_W'(wide));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        i_cfg_valid <= 1'b0;
        cfg_pattern = pat;
        cfg_wide    = wide;
        cfg_width   = w;
        cfg_height  = h;
    endtask

    task automatic send_pixel(input t_pix_in p, input logic typed, input t_pix_out typed_exp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_pixels.push_back(typed ? typed_exp : predict_pixel(p));
    endtask

    // drop valid, let every expected item come back, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return 10'd1023;
            2:       return 10'd512;
            3:       return DIM_W'($urandom_range(1, 16));
            default: return DIM_W'($urandom_range(1, 512));
        endcase
    endfunction

    // receiver: random stall bursts plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            i_out_stall <= 1'b1;
            stall_left  <= LONG_HOLD;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : out_check
        t_pix_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("item with nothing expected", 32'(o_out_data), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.pixel_word !== want.pixel_word) begin
                    report_mismatch("pixel_word", 32'(o_out_data.pixel_word),
                                    32'(want.pixel_word));
                end
                if (o_out_data.byte_count !== want.byte_count) begin
                    report_mismatch("byte_count", 32'(o_out_data.byte_count),
                                    32'(want.byte_count));
                end
                if (o_out_data.covered !== want.covered) begin
                    report_mismatch("covered", 32'(o_out_data.covered), 32'(want.covered));
                end
            end
            pixels_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        dir_row_t         row;
        t_pix_in          pix;
        t_pix_out         typed_exp;
        int unsigned      eff_w, eff_h;
        logic [PAT_W-1:0] pat;
        logic             wide;
        logic [DIM_W-1:0] w, h;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        foreach (DIR_TABLE[i]) begin
            row = DIR_TABLE[i];
            if (row.pattern != cfg_pattern || row.wide != cfg_wide
                    || row.width != cfg_width || row.height != cfg_height) begin
                wait_drained();
                set_config(row.pattern, row.wide, row.width, row.height);
            end
            pix.pixel_x = row.x;
            pix.pixel_y = row.y;
            typed_exp.pixel_word = row.word;
            typed_exp.byte_count = row.wide ? BCNT_RGB888 : BCNT_RGB565;
            typed_exp.covered    = row.cov;
            send_pixel(pix, row.typed, typed_exp);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            // favor the bar pattern, it has the most arithmetic behind it
            pat  = ($urandom_range(0, 11) > 7) ? PAT_BARS : PAT_W'($urandom_range(0, 7));
            wide = 1'($urandom_range(0, 1));
            if (phase < 2) begin
                w = 10'd512;
                h = 10'd512;
            end else begin
                w = pick_dim();
                h = pick_dim();
            end
            wait_drained();
            set_config(pat, wide, w, h);
            idle_on = (phase != QUIET_PHASE && phase != RAND_PHASES - 1);
            if (phase == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            eff_w = clamp_dim(w, MAX_WIDTH_DEF);
            eff_h = clamp_dim(h, MAX_HEIGHT_DEF);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pix.pixel_x = ($urandom_range(0, 6) != 0) ? COORD_W'($urandom_range(0, eff_w - 1))
                                                          : COORD_W'($urandom_range(0, 511));
                pix.pixel_y = ($urandom_range(0, 6) != 0) ? COORD_W'($urandom_range(0, eff_h - 1))
                                                          : COORD_W'($urandom_range(0, 511));
                send_pixel(pix, 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/dtpg_pkg.sv
rtl/dtpg_front.sv
rtl/dtpg_div_stage.sv
rtl/dtpg_pack.sv
rtl/display_test_pattern_generator.sv
tb/tb_top.sv
